// ===== hdl/awb_pkg.sv =====
// ----------------------------------------------------------------------------
// awb_pkg
// Shared types and constants of the affine warp bilinear core.
// ----------------------------------------------------------------------------
package awb_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 8;
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COEF_W     = 32;
  localparam int SIZE_W     = 9;
  localparam int FRAC_W     = 17;
  localparam int HALF_W     = POS_W - 1;
  localparam int BANK_AW    = 2 * HALF_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int PIX_W      = 3 * SAMPLE_W;
  localparam int IDX_W      = 4;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_WARP = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_COEF_XX    = 4'd0,
    REG_COEF_XY    = 4'd1,
    REG_COEF_XC    = 4'd2,
    REG_COEF_YX    = 4'd3,
    REG_COEF_YY    = 4'd4,
    REG_COEF_YC    = 4'd5,
    REG_SRC_WIDTH  = 4'd6,
    REG_SRC_HEIGHT = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic valid;
    logic warp;
    logic three;
    logic in_bounds;
  } ctl_t;

  typedef struct packed {
    ctl_t                ctl;
    logic [POS_W-1:0]    col;
    logic [POS_W-1:0]    row;
    logic [SAMPLE_W-1:0] ch0;
    logic [SAMPLE_W-1:0] ch1;
    logic [SAMPLE_W-1:0] ch2;
  } item_t;

endpackage

// ===== hdl/awb_coord.sv =====
// ----------------------------------------------------------------------------
// awb_coord
// Three-stage affine mapping of a destination position to source position.
// ----------------------------------------------------------------------------
module awb_coord import awb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  item_t                    in_item,
  input  logic signed [COEF_W-1:0] coef_xx,
  input  logic signed [COEF_W-1:0] coef_xy,
  input  logic signed [COEF_W-1:0] coef_xc,
  input  logic signed [COEF_W-1:0] coef_yx,
  input  logic signed [COEF_W-1:0] coef_yy,
  input  logic signed [COEF_W-1:0] coef_yc,
  input  logic [SIZE_W-1:0]        src_width,
  input  logic [SIZE_W-1:0]        src_height,
  output item_t                    out_item,
  output logic [POS_W-1:0]         ix,
  output logic [POS_W-1:0]         iy,
  output logic signed [FRAC_W-1:0] fx,
  output logic signed [FRAC_W-1:0] fy
);

  localparam int PROD_W = COEF_W + POS_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int INT_W  = SUM_W - 16;

  item_t                    item1, item2, co_next;
  logic signed [PROD_W-1:0] mxx, mxy, myx, myy;
  logic signed [SUM_W-1:0]  sx, sy;
  logic signed [POS_W:0]    colx, rowx;
  logic                     nx, ny, inside_next;
  logic signed [INT_W-1:0]  tix, tiy, lim_w, lim_h;
  logic [SIZE_W-1:0]        w_eff, h_eff;

  assign colx = {1'b0, in_item.col};
  assign rowx = {1'b0, in_item.row};

  always_comb begin
    w_eff = (src_width > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : src_width;
    h_eff = (src_height > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : src_height;
    lim_w = $signed({{(INT_W-SIZE_W){1'b0}}, w_eff}) - INT_W'(2);
    lim_h = $signed({{(INT_W-SIZE_W){1'b0}}, h_eff}) - INT_W'(2);
    nx    = sx[SUM_W-1] && (sx[15:0] != 16'd0);
    ny    = sy[SUM_W-1] && (sy[15:0] != 16'd0);
    tix   = sx[SUM_W-1:16] + INT_W'(nx);
    tiy   = sy[SUM_W-1:16] + INT_W'(ny);
    inside_next = !tix[INT_W-1] && (tix <= lim_w) && !tiy[INT_W-1] && (tiy <= lim_h);
    co_next = item2;
    co_next.ctl.in_bounds = inside_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item1.ctl.valid    <= 1'b0;
      item2.ctl.valid    <= 1'b0;
      out_item.ctl.valid <= 1'b0;
    end else if (en) begin
      item1    <= in_item;
      mxx      <= coef_xx * colx;
      mxy      <= coef_xy * rowx;
      myx      <= coef_yx * colx;
      myy      <= coef_yy * rowx;
      item2    <= item1;
      sx       <= SUM_W'(mxx) + SUM_W'(mxy) + SUM_W'(coef_xc);
      sy       <= SUM_W'(myx) + SUM_W'(myy) + SUM_W'(coef_yc);
      out_item <= co_next;
      ix       <= tix[POS_W-1:0];
      iy       <= tiy[POS_W-1:0];
      fx       <= {nx, sx[15:0]};
      fy       <= {ny, sy[15:0]};
    end
  end

endmodule

// ===== hdl/awb_store.sv =====
// ----------------------------------------------------------------------------
// awb_store
// Source image store in four banks by row and column parity, giving the
// whole 2x2 neighborhood at once.
// ----------------------------------------------------------------------------
module awb_store import awb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  item_t                    in_item,
  input  logic [POS_W-1:0]         ix,
  input  logic [POS_W-1:0]         iy,
  input  logic signed [FRAC_W-1:0] fx,
  input  logic signed [FRAC_W-1:0] fy,
  output item_t                    out_item,
  output logic signed [FRAC_W-1:0] fx_q,
  output logic signed [FRAC_W-1:0] fy_q,
  output logic [PIX_W-1:0]         s00,
  output logic [PIX_W-1:0]         s01,
  output logic [PIX_W-1:0]         s10,
  output logic [PIX_W-1:0]         s11
);

  logic [PIX_W-1:0]   mem [4][BANK_DEPTH];
  logic [PIX_W-1:0]   rd [4];
  logic [BANK_AW-1:0] addr [4];
  logic [3:0]         we;
  logic [PIX_W-1:0]   wdata;
  logic [HALF_W-1:0]  col_e, col_o, row_e, row_o;
  logic               px, py;

  always_comb begin
    col_e = ix[POS_W-1:1] + HALF_W'(ix[0]);
    col_o = ix[POS_W-1:1];
    row_e = iy[POS_W-1:1] + HALF_W'(iy[0]);
    row_o = iy[POS_W-1:1];
    wdata = {in_item.ctl.three ? in_item.ch2 : '0,
             in_item.ctl.three ? in_item.ch1 : '0, in_item.ch0};
    we    = '0;
    if (in_item.ctl.warp == ACT_WARP) begin
      addr[0] = {row_e, col_e};
      addr[1] = {row_e, col_o};
      addr[2] = {row_o, col_e};
      addr[3] = {row_o, col_o};
    end else begin
      for (int g = 0; g < 4; g++) begin
        addr[g] = {in_item.row[POS_W-1:1], in_item.col[POS_W-1:1]};
      end
      we[{in_item.row[0], in_item.col[0]}] = in_item.ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 4; g++) begin
        if (we[g]) begin
          mem[g][addr[g]] <= wdata;
        end
        rd[g] <= mem[g][addr[g]];
      end
      fx_q     <= fx;
      fy_q     <= fy;
      px       <= ix[0];
      py       <= iy[0];
    end
    if (rst) begin
      out_item.ctl.valid <= 1'b0;
    end else if (en) begin
      out_item <= in_item;
    end
  end

  assign s00 = rd[{py, px}];
  assign s01 = rd[{py, ~px}];
  assign s10 = rd[{~py, px}];
  assign s11 = rd[{~py, ~px}];

endmodule

// ===== hdl/awb_blend.sv =====
// ----------------------------------------------------------------------------
// awb_blend
// Six-stage bilinear blend of one channel with rounding and saturation.
// ----------------------------------------------------------------------------
module awb_blend import awb_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [FRAC_W-1:0] fa,
  input  logic signed [FRAC_W-1:0] fb,
  input  logic [SAMPLE_W-1:0]      s00,
  input  logic [SAMPLE_W-1:0]      s01,
  input  logic [SAMPLE_W-1:0]      s10,
  input  logic [SAMPLE_W-1:0]      s11,
  output logic [SAMPLE_W-1:0]      res
);

  localparam int M_W = 2 * FRAC_W;
  localparam int P_W = 36;
  localparam int D_W = P_W + 1;
  localparam int B_W = D_W + FRAC_W;
  localparam int X_W = 56;
  localparam int R_W = X_W - 32;

  logic signed [FRAC_W-1:0] d0, d1, a1, b1, b2, b3, b4;
  logic [SAMPLE_W-1:0]      base0, base1, base0_2, base1_2;
  logic signed [M_W-1:0]    m0, m1;
  logic signed [P_W-1:0]    p0, p1, p0_4, p0_5;
  logic signed [D_W-1:0]    dd;
  logic signed [B_W-1:0]    bd;
  logic signed [X_W-1:0]    xs;
  logic signed [R_W-1:0]    rq;
  logic [SAMPLE_W-1:0]      res_next;

  always_comb begin
    xs = (X_W'(p0_5) <<< 16) + X_W'(bd) + (X_W'(1) <<< 31);
    rq = xs[X_W-1:32];
    if (rq < 0) begin
      res_next = '0;
    end else if (rq > R_W'(65535)) begin
      res_next = '1;
    end else begin
      res_next = rq[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0      <= $signed({1'b0, s01}) - $signed({1'b0, s00});
      d1      <= $signed({1'b0, s11}) - $signed({1'b0, s10});
      base0   <= s00;
      base1   <= s10;
      a1      <= fa;
      b1      <= fb;
      m0      <= a1 * d0;
      m1      <= a1 * d1;
      base0_2 <= base0;
      base1_2 <= base1;
      b2      <= b1;
      p0      <= $signed({4'b0, base0_2, 16'b0}) + P_W'(m0);
      p1      <= $signed({4'b0, base1_2, 16'b0}) + P_W'(m1);
      b3      <= b2;
      dd      <= D_W'(p1) - D_W'(p0);
      p0_4    <= p0;
      b4      <= b3;
      bd      <= b4 * dd;
      p0_5    <= p0_4;
      res     <= res_next;
    end
  end

endmodule

// ===== hdl/affine_warp_bilinear_core.sv =====
// Each warp word passes coordinate mapping, the store read and the blend.
// Throughput: one word per cycle unless stalled; load/warp words mix freely.
// The four-bank parity store reads the whole 2x2 neighborhood at once.
// A held result stalls the whole pipeline, which then holds every stage.
// Reset clears valid bits and restores the identity transform and 256x256.
// The image store is not cleared by reset.
// ----------------------------------------------------------------------------
// affine_warp_bilinear_core
// Affine warp of a loaded source image with bilinear interpolation.
// ----------------------------------------------------------------------------
module affine_warp_bilinear_core import awb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic [POS_W-1:0]     column,
  input  logic [POS_W-1:0]     row,
  input  logic                 three_channels,
  input  logic [SAMPLE_W-1:0]  in_ch0,
  input  logic [SAMPLE_W-1:0]  in_ch1,
  input  logic [SAMPLE_W-1:0]  in_ch2,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SAMPLE_W-1:0]  out_ch0,
  output logic [SAMPLE_W-1:0]  out_ch1,
  output logic [SAMPLE_W-1:0]  out_ch2,
  output logic                 inside_res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  localparam int BL_DEPTH = 6;

  logic signed [COEF_W-1:0] coef_xx, coef_xy, coef_xc, coef_yx, coef_yy, coef_yc;
  logic [SIZE_W-1:0]        src_width, src_height;
  logic                     en;
  item_t                    in_item, co_item, st_item;
  logic [POS_W-1:0]         co_ix, co_iy;
  logic signed [FRAC_W-1:0] co_fx, co_fy, st_fx, st_fy;
  logic [PIX_W-1:0]         s00, s01, s10, s11;
  logic [SAMPLE_W-1:0]      bl_res [3];
  ctl_t                     bctl [BL_DEPTH];
  ctl_t                     octl;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_xx    <= COEF_W'(65536);
      coef_xy    <= '0;
      coef_xc    <= '0;
      coef_yx    <= '0;
      coef_yy    <= COEF_W'(65536);
      coef_yc    <= '0;
      src_width  <= SIZE_W'(256);
      src_height <= SIZE_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_COEF_XX:    coef_xx    <= cfg_data;
        REG_COEF_XY:    coef_xy    <= cfg_data;
        REG_COEF_XC:    coef_xc    <= cfg_data;
        REG_COEF_YX:    coef_yx    <= cfg_data;
        REG_COEF_YY:    coef_yy    <= cfg_data;
        REG_COEF_YC:    coef_yc    <= cfg_data;
        REG_SRC_WIDTH:  src_width  <= cfg_data[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.ctl.valid     = in_valid;
    in_item.ctl.warp      = action;
    in_item.ctl.three     = three_channels;
    in_item.ctl.in_bounds = 1'b0;
    in_item.col           = column;
    in_item.row           = row;
    in_item.ch0           = in_ch0;
    in_item.ch1           = in_ch1;
    in_item.ch2           = in_ch2;
  end

  awb_coord u_coord (
    .clk, .rst, .en, .in_item,
    .coef_xx, .coef_xy, .coef_xc, .coef_yx, .coef_yy, .coef_yc,
    .src_width, .src_height,
    .out_item (co_item),
    .ix       (co_ix),
    .iy       (co_iy),
    .fx       (co_fx),
    .fy       (co_fy)
  );

  awb_store u_store (
    .clk, .rst, .en,
    .in_item  (co_item),
    .ix       (co_ix),
    .iy       (co_iy),
    .fx       (co_fx),
    .fy       (co_fy),
    .out_item (st_item),
    .fx_q     (st_fx),
    .fy_q     (st_fy),
    .s00, .s01, .s10, .s11
  );

  for (genvar c = 0; c < 3; c++) begin : g_chan
    awb_blend u_blend (
      .clk, .en,
      .fa  (st_fx),
      .fb  (st_fy),
      .s00 (s00[c*SAMPLE_W +: SAMPLE_W]),
      .s01 (s01[c*SAMPLE_W +: SAMPLE_W]),
      .s10 (s10[c*SAMPLE_W +: SAMPLE_W]),
      .s11 (s11[c*SAMPLE_W +: SAMPLE_W]),
      .res (bl_res[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BL_DEPTH; i++) begin
        bctl[i].valid <= 1'b0;
      end
    end else if (en) begin
      bctl[0] <= st_item.ctl;
      for (int i = 1; i < BL_DEPTH; i++) begin
        bctl[i] <= bctl[i-1];
      end
    end
  end

  assign octl       = bctl[BL_DEPTH-1];
  assign out_valid  = octl.valid && (octl.warp == ACT_WARP);
  assign inside_res = octl.in_bounds;
  assign out_ch0    = octl.in_bounds ? bl_res[0] : '0;
  assign out_ch1    = (octl.in_bounds && octl.three) ? bl_res[1] : '0;
  assign out_ch2    = (octl.in_bounds && octl.three) ? bl_res[2] : '0;

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_res |-> out_ch0 == '0 && out_ch1 == '0 && out_ch2 == '0)
    else $error("outside result carries nonzero samples");

  a_inside_range: assert property (@(posedge clk) disable iff (rst)
    co_item.ctl.valid && co_item.ctl.warp && co_item.ctl.in_bounds
      |-> co_ix != '1 && co_iy != '1)
    else $error("inside neighborhood runs past the store edge");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(st_item.ctl) && $stable(co_item.ctl))
    else $error("pipeline moved during a stall");

endmodule

// ===== test/affine_warp_bilinear_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_warp_bilinear_core_tb
// Loads source pixels, changes the affine transform and source size between
// phases, and checks every warped pixel against a fixed-point predictor of
// the truncating, bilinear, saturating datapath under random flow control.
// ----------------------------------------------------------------------------
module affine_warp_bilinear_core_tb;
  import awb_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [SAMPLE_W-1:0] c0;
    logic [SAMPLE_W-1:0] c1;
    logic [SAMPLE_W-1:0] c2;
    logic                in_bounds;
  } pixel_t;

  class warp_scoreboard;
    logic [PIX_W-1:0] image [MAX_WIDTH*MAX_HEIGHT];
    bit               filled [MAX_WIDTH*MAX_HEIGHT];
    longint           m_xx, m_xy, m_xc, m_yx, m_yy, m_yc;
    int               img_w, img_h;
    pixel_t           pending_pixels [$];
    int               errors;

    function new();
      m_xx = 65536; m_xy = 0; m_xc = 0;
      m_yx = 0; m_yy = 65536; m_yc = 0;
      img_w = 256; img_h = 256;
    endfunction

    function void set_reg(reg_idx_t idx, logic [COEF_W-1:0] d);
      longint s;
      s = longint'(signed'(d));
      case (idx)
        REG_COEF_XX: m_xx = s;
        REG_COEF_XY: m_xy = s;
        REG_COEF_XC: m_xc = s;
        REG_COEF_YX: m_yx = s;
        REG_COEF_YY: m_yy = s;
        REG_COEF_YC: m_yc = s;
        REG_SRC_WIDTH: img_w = int'(d[SIZE_W-1:0]);
        REG_SRC_HEIGHT: img_h = int'(d[SIZE_W-1:0]);
        default: ;
      endcase
    endfunction

    function void map_point(logic [POS_W-1:0] c, logic [POS_W-1:0] r, output bit ins,
                            output longint ix, output longint iy, output longint fa,
                            output longint fb);
      longint sx, sy, lw, lh;
      sx = m_xx * longint'(c) + m_xy * longint'(r) + m_xc;
      sy = m_yx * longint'(c) + m_yy * longint'(r) + m_yc;
      ix = sx / 65536;
      iy = sy / 65536;
      fa = sx - ix * 65536;
      fb = sy - iy * 65536;
      lw = (img_w < MAX_WIDTH) ? img_w : MAX_WIDTH;
      lh = (img_h < MAX_HEIGHT) ? img_h : MAX_HEIGHT;
      ins = !(ix < 0 || ix > lw - 2 || iy < 0 || iy > lh - 2);
    endfunction

    function longint fdiv16(longint v);
      if (v >= 0) return v / 65536;
      return -(((-v) + 65535) / 65536);
    endfunction

    function logic [SAMPLE_W-1:0] lerp2d(longint fa, longint fb, longint s00, longint s01,
                                         longint s10, longint s11);
      longint p0, p1, d, dq, dr, u, r;
      p0 = s00 * 65536 + fa * (s01 - s00);
      p1 = s10 * 65536 + fa * (s11 - s10);
      d = p1 - p0;
      dq = fdiv16(d);
      dr = d - dq * 65536;
      u = p0 + fb * dq + fdiv16(fb * dr);
      r = fdiv16(u + 32768);
      if (r < 0) return '0;
      if (r > 65535) return 16'hFFFF;
      return r[SAMPLE_W-1:0];
    endfunction

    function void note(logic act, logic [POS_W-1:0] c, logic [POS_W-1:0] r, logic th,
                       logic [SAMPLE_W-1:0] d0, logic [SAMPLE_W-1:0] d1,
                       logic [SAMPLE_W-1:0] d2);
      pixel_t p;
      bit ins;
      longint ix, iy, fa, fb;
      int a00;
      if (act == ACT_LOAD) begin
        a00 = int'(r) * MAX_WIDTH + int'(c);
        image[a00] = {th ? d2 : 16'h0, th ? d1 : 16'h0, d0};
        filled[a00] = 1;
        return;
      end
      map_point(c, r, ins, ix, iy, fa, fb);
      p = '{default: '0};
      if (ins) begin
        a00 = int'(iy) * MAX_WIDTH + int'(ix);
        p.in_bounds = 1;
        for (int k = 0; k < (th ? 3 : 1); k++) begin
          logic [SAMPLE_W-1:0] v;
          v = lerp2d(fa, fb, image[a00][k*SAMPLE_W +: SAMPLE_W],
                     image[a00+1][k*SAMPLE_W +: SAMPLE_W],
                     image[a00+MAX_WIDTH][k*SAMPLE_W +: SAMPLE_W],
                     image[a00+MAX_WIDTH+1][k*SAMPLE_W +: SAMPLE_W]);
          if (k == 0) p.c0 = v;
          else if (k == 1) p.c1 = v;
          else p.c2 = v;
        end
      end
      pending_pixels.push_back(p);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check(pixel_t got);
      pixel_t e;
      if (pending_pixels.size() == 0) begin
        report("result word with no warp request waiting");
        return;
      end
      e = pending_pixels.pop_front();
      if (got.c0 !== e.c0) report($sformatf("out_ch0 %h expected %h", got.c0, e.c0));
      if (got.c1 !== e.c1) report($sformatf("out_ch1 %h expected %h", got.c1, e.c1));
      if (got.c2 !== e.c2) report($sformatf("out_ch2 %h expected %h", got.c2, e.c2));
      if (got.in_bounds !== e.in_bounds)
        report($sformatf("inside_res %b expected %b", got.in_bounds, e.in_bounds));
    endtask
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                action = ACT_LOAD;
  logic [POS_W-1:0]    column = '0;
  logic [POS_W-1:0]    row = '0;
  logic                three_channels = 1'b0;
  logic [SAMPLE_W-1:0] in_ch0 = '0;
  logic [SAMPLE_W-1:0] in_ch1 = '0;
  logic [SAMPLE_W-1:0] in_ch2 = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SAMPLE_W-1:0] out_ch0;
  logic [SAMPLE_W-1:0] out_ch1;
  logic [SAMPLE_W-1:0] out_ch2;
  logic                inside_res;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [COEF_W-1:0]   cfg_data = '0;

  warp_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  logic hold_start = 1'b0;
  int  quiet_cycles = 0;
  int  sent_words = 0;

  affine_warp_bilinear_core i_dut (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    static int  hold_left = 0;
    static bit  hold_used = 0;
    if (hold_start && !hold_used) begin
      hold_used = 1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      quiet_cycles++;
      if ((in_valid && in_ready) || (cfg_valid && cfg_ready)) quiet_cycles = 0;
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        sb.check('{c0: out_ch0, c1: out_ch1, c2: out_ch2, in_bounds: inside_res});
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_word(logic act, logic [POS_W-1:0] c, logic [POS_W-1:0] r, logic th,
                           logic [SAMPLE_W-1:0] d0, logic [SAMPLE_W-1:0] d1,
                           logic [SAMPLE_W-1:0] d2);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    action <= act;
    column <= c;
    row <= r;
    three_channels <= th;
    in_ch0 <= d0;
    in_ch1 <= d1;
    in_ch2 <= d2;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    sb.note(act, c, r, th, d0, d1, d2);
    sent_words++;
    @(posedge clk);
  endtask

  task automatic load_random(logic [POS_W-1:0] c, logic [POS_W-1:0] r);
    send_word(ACT_LOAD, c, r, 1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Loads any unwritten neighbor first so that no warp reads an empty entry.
  task automatic warp_word(logic [POS_W-1:0] c, logic [POS_W-1:0] r, logic th);
    bit ins;
    longint ix, iy, fa, fb;
    int a00;
    sb.map_point(c, r, ins, ix, iy, fa, fb);
    if (ins) begin
      a00 = int'(iy) * MAX_WIDTH + int'(ix);
      for (int k = 0; k < 4; k++) begin
        int ad;
        ad = a00 + (k / 2) * MAX_WIDTH + (k % 2);
        if (!sb.filled[ad]) load_random(POS_W'(ad % MAX_WIDTH), POS_W'(ad / MAX_WIDTH));
      end
    end
    send_word(ACT_WARP, c, r, th, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [COEF_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    sb.set_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic run_phase(logic [COEF_W-1:0] regs [8], int words, int mode, bit squeeze);
    int stop_at;
    settle();
    for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), regs[i]);
    cfg_valid <= 1'b0;
    send_idle_pct = (mode == 1) ? 70 : (mode == 3) ? 6 : 0;
    recv_stall_pct = (mode == 2) ? 70 : (mode == 3) ? 6 : 0;
    if (squeeze) hold_start <= 1'b1;
    stop_at = sent_words + words;
    while (sent_words < stop_at) begin
      if ($urandom_range(99) < 25)
        load_random(POS_W'($urandom), POS_W'($urandom));
      else
        warp_word(POS_W'($urandom), POS_W'($urandom), 1'($urandom));
    end
  endtask

  function automatic logic [COEF_W-1:0] q16(int lo, int hi);
    return COEF_W'($signed($urandom_range(hi - lo)) + lo);
  endfunction

  initial begin
    logic [COEF_W-1:0] regs [8];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(ACT_LOAD, 8'd0, 8'd0, 1'b1, 16'h0000, 16'hFFFF, 16'h0000);
    send_word(ACT_LOAD, 8'd1, 8'd0, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_word(ACT_LOAD, 8'd0, 8'd1, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_word(ACT_LOAD, 8'd1, 8'd1, 1'b0, 16'h8001, 16'hFFFF, 16'hFFFF);
    send_word(ACT_LOAD, 8'd254, 8'd254, 1'b0, 16'hFFFF, 16'h1234, 16'h5678);
    send_word(ACT_LOAD, 8'd255, 8'd254, 1'b1, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_word(ACT_LOAD, 8'd254, 8'd255, 1'b1, 16'hFFFF, 16'h0000, 16'h0000);
    send_word(ACT_LOAD, 8'd255, 8'd255, 1'b1, 16'h0001, 16'hFFFF, 16'hAAAA);
    warp_word(8'd0, 8'd0, 1'b1);
    warp_word(8'd0, 8'd0, 1'b0);
    warp_word(8'd1, 8'd1, 1'b1);
    warp_word(8'd254, 8'd254, 1'b1);
    warp_word(8'd254, 8'd254, 1'b0);
    warp_word(8'd255, 8'd255, 1'b1);
    warp_word(8'd255, 8'd0, 1'b1);
    warp_word(8'd0, 8'd255, 1'b0);
    send_word(ACT_LOAD, 8'd0, 8'd0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    warp_word(8'd0, 8'd0, 1'b1);
    send_word(ACT_LOAD, 8'd1, 8'd1, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    warp_word(8'd0, 8'd0, 1'b1);

    // Half-pixel and negative-fraction offsets around the origin.
    regs = '{32'h0001_0000, 32'h0, 32'h0000_8000, 32'h0, 32'h0001_0000, 32'hFFFF_C000,
             32'd256, 32'd256};
    run_phase(regs, 190, 0, 0);
    regs = '{32'h0000_8123, 32'h0000_1000, 32'hFFFE_8000, 32'hFFFF_F800, 32'h0000_9000,
             32'h0000_3000, 32'd200, 32'd150};
    run_phase(regs, 190, 1, 0);
    regs = '{32'h0000_E000, 32'hFFFF_9000, 32'h0040_0000, 32'h0000_7000, 32'h0000_E000,
             32'hFFE0_0000, 32'd256, 32'd256};
    run_phase(regs, 190, 2, 1);
    regs = '{32'h0000_0100, 32'h0, 32'h0, 32'h0, 32'h0000_0100, 32'hFFFF_FF00, 32'd2, 32'd2};
    run_phase(regs, 190, 3, 0);
    regs = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'd256, 32'd2};
    run_phase(regs, 120, 0, 0);
    regs = '{32'h0000_0200, 32'h0, 32'hFFFF_0001, 32'h0, 32'h0001_0000, 32'h0, 32'd3,
             32'd256};
    run_phase(regs, 160, 1, 0);
    for (int p = 0; p < 3; p++) begin
      regs = '{q16(-131072, 131072), q16(-65536, 65536), q16(-524288, 16777216),
               q16(-65536, 65536), q16(-131072, 131072), q16(-524288, 16777216),
               32'($urandom_range(256, 2)), 32'($urandom_range(256, 2))};
      run_phase(regs, 170, (p + 2) % 4, 0);
    end

    settle();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
